// ===== src/sds_pkg.sv =====
// Shared types and constants for the stream delimiter splitter.
package sds_pkg;

	localparam int MAX_DELIM_LEN = 8;
	// Delimiter length and byte counts must hold MAX_DELIM_LEN itself.
	localparam int LEN_W = $clog2(MAX_DELIM_LEN + 1);
	// The window never holds a full delimiter between items, so it needs one code less.
	localparam int FILL_W = $clog2(MAX_DELIM_LEN);
	localparam int DESC_DEPTH = 4;
	localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
	localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	typedef logic [7:0] byte_t;
	typedef byte_t [MAX_DELIM_LEN-1:0] row_t;

	typedef enum logic [1:0] {
		REG_DELIM_BYTES = 2'd0,
		REG_DELIM_LEN   = 2'd1,
		REG_KEEP        = 2'd2
	} reg_idx_t;

	// Everything one request produces, packed so the expander can replay it.
	typedef struct packed {
		row_t             bytes;
		logic [LEN_W-1:0] n_content;
		logic             match;
		logic [LEN_W-1:0] n_keep;
		logic             last;
	} desc_t;

	typedef struct packed {
		byte_t out_byte;
		logic  out_has_byte;
		logic  segment_kind;
		logic  segment_end;
		logic  stream_end;
		logic  burst_last;
	} res_t;

endpackage

// ===== src/sds_cell.sv =====
// One window cell: holds a byte and compares it against the delimiter at every alignment.
module sds_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sds_pkg::byte_t    new_byte,
	input  logic              take_new,
	input  logic              load,
	input  sds_pkg::byte_t    next_byte,
	input  sds_pkg::row_t     dview,
	output sds_pkg::byte_t    p_byte,
	output logic [sds_pkg::MAX_DELIM_LEN-1:0] eq
);
	import sds_pkg::*;

	byte_t w_q;

	// The cell at the write position sees the incoming byte in place of its own.
	assign p_byte = take_new ? new_byte : w_q;

	always_comb begin
		for (int k = 0; k < MAX_DELIM_LEN; k++) begin
			eq[k] = (p_byte == dview[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (load) begin
			w_q <= next_byte;
		end
	end

endmodule

// ===== src/sds_desc_fifo.sv =====
// Small queue of per-request descriptors between the window and the expander.
module sds_desc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sds_pkg::desc_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output sds_pkg::desc_t head_data
);
	import sds_pkg::*;

	desc_t                 mem [DESC_DEPTH];
	logic [DESC_PTR_W-1:0] wr_ptr_q;
	logic [DESC_PTR_W-1:0] rd_ptr_q;
	logic [DESC_CNT_W-1:0] count_q;

	assign full      = (count_q == DESC_CNT_W'(DESC_DEPTH));
	assign avail     = (count_q != '0);
	assign head_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/sds_expander.sv =====
// Replays one descriptor as a burst of results, one per cycle unless the output stalls, shifting its bytes out.
module sds_expander (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           desc_avail,
	input  sds_pkg::desc_t desc,
	output logic           desc_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output sds_pkg::res_t  res
);
	import sds_pkg::*;

	typedef enum logic [1:0] {
		PH_CONTENT,
		PH_MARK,
		PH_KEEP,
		PH_FINAL
	} phase_t;

	logic             busy_q;
	row_t             row_q;
	logic [LEN_W-1:0] nc_q;
	logic             mark_q;
	logic [LEN_W-1:0] nk_q;
	logic             last_q;

	phase_t phase;
	logic   more;
	logic   adv;
	logic   done;
	logic   load;

	always_comb begin
		if (nc_q != '0) begin
			phase = PH_CONTENT;
		end else if (mark_q) begin
			phase = PH_MARK;
		end else if (nk_q != '0) begin
			phase = PH_KEEP;
		end else begin
			phase = PH_FINAL;
		end

		res = '0;
		case (phase)
			PH_CONTENT: begin
				res.out_byte     = row_q[0];
				res.out_has_byte = 1'b1;
				more = (nc_q != LEN_W'(1)) || mark_q || (nk_q != '0) || last_q;
			end
			PH_MARK: begin
				res.segment_end = 1'b1;
				more = (nk_q != '0) || last_q;
			end
			PH_KEEP: begin
				res.out_byte     = row_q[0];
				res.out_has_byte = 1'b1;
				res.segment_kind = 1'b1;
				res.segment_end  = (nk_q == LEN_W'(1));
				more = (nk_q != LEN_W'(1)) || last_q;
			end
			default: begin
				res.segment_end = 1'b1;
				res.stream_end  = 1'b1;
				more = 1'b0;
			end
		endcase
		res.burst_last = !more;
	end

	assign out_valid = busy_q;
	assign adv       = busy_q && !out_stall;
	assign done      = adv && !more;
	assign load      = desc_avail && (!busy_q || done);
	assign desc_pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nc_q   <= '0;
			mark_q <= 1'b0;
			nk_q   <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			nc_q   <= desc.n_content;
			mark_q <= desc.match;
			nk_q   <= desc.n_keep;
			last_q <= desc.last;
		end else if (done) begin
			busy_q <= 1'b0;
			nc_q   <= '0;
			mark_q <= 1'b0;
			nk_q   <= '0;
			last_q <= 1'b0;
		end else if (adv) begin
			case (phase)
				PH_CONTENT: nc_q <= nc_q - 1'b1;
				PH_MARK:    mark_q <= 1'b0;
				PH_KEEP:    nk_q <= nk_q - 1'b1;
				default:    last_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= desc.bytes;
		end else if (adv && (phase == PH_CONTENT || phase == PH_KEEP)) begin
			row_q <= row_t'(row_q >> 8);
		end
	end

endmodule

// ===== src/stream_delimiter_splitter_core.sv =====
// Top level of the stream delimiter splitter: window cells, descriptor queue and expander.
//
// The block cuts a byte stream into segments at a delimiter of 1 to 8 bytes, matching
// leftmost and without overlap. A row of eight window cells holds the bytes that could still
// start a delimiter; every cell compares its byte against the delimiter at all alignments in
// parallel, so each incoming request is resolved in the cycle it is accepted and a new request
// can be taken every cycle. What a request produces (released content bytes, a close mark,
// the delimiter bytes in keep mode, the stream-end flush and final mark) is packed into one
// descriptor and queued in a four-entry queue. The expander then replays each descriptor as
// results, exactly one result per cycle unless the output stalls, and a request whose byte
// stays in the window yields none. The first result of a request passes through the
// descriptor queue and the expander registers before it appears. The input stalls only when the
// descriptor queue is full, which happens when bursts arrive faster than the output drains.
// Registers sit at byte addresses 0 (delimiter bytes, first byte in bits 7:0), 8 (delimiter
// length; 0 acts as 1 and values above 8 act as 8) and 16 (keep delimiters); they should be
// written only while no request is in flight. Bytes still held in the window when the
// delimiter changes are re-examined against the new delimiter on the next byte.
module stream_delimiter_splitter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         byte_valid,
	input  logic                         stream_last,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         out_has_byte,
	output logic                         segment_kind,
	output logic                         segment_end,
	output logic                         stream_end,
	output logic                         burst_last,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sds_pkg::PADDR_W-1:0]  paddr,
	input  logic [sds_pkg::PDATA_W-1:0]  pwdata,
	output logic [sds_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import sds_pkg::*;

	// Configuration registers.
	logic [PDATA_W-1:0] delim_bytes_q;
	logic [LEN_W-1:0]   delim_len_q;
	logic               keep_q;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic [LEN_W-1:0]   len_eff;
	row_t               delim_row;

	// Window state.
	logic [FILL_W-1:0]  fill_q;
	row_t               p_row;
	row_t               next_row;
	row_t               dview_a [MAX_DELIM_LEN];
	logic [MAX_DELIM_LEN-1:0] eq_m [MAX_DELIM_LEN];
	logic [MAX_DELIM_LEN-1:0] take_new;
	logic               win_load;

	logic               in_acc;
	logic [LEN_W-1:0]   f;
	logic [MAX_DELIM_LEN-1:0] cand;
	logic [LEN_W-1:0]   k_sel;
	logic [LEN_W-1:0]   rem;
	logic               hit;
	logic [LEN_W-1:0]   nc;
	desc_t              push_desc;
	logic               push;

	logic               fifo_full;
	logic               fifo_avail;
	desc_t              head_desc;
	logic               fifo_pop;
	res_t               res;

	// APB register file. The register index is taken from the address bits above the
	// 8-byte lane; index values beyond the list are ignored on write and read as zero.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= '0;
			delim_len_q   <= LEN_W'(1);
			keep_q        <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DELIM_BYTES: delim_bytes_q <= pwdata;
				REG_DELIM_LEN:   delim_len_q <= pwdata[LEN_W-1:0];
				REG_KEEP:        keep_q <= pwdata[0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DELIM_BYTES: prdata = delim_bytes_q;
			REG_DELIM_LEN:   prdata = PDATA_W'(delim_len_q);
			REG_KEEP:        prdata = PDATA_W'(keep_q);
			default:         prdata = '0;
		endcase
	end

	// A length of zero behaves as one byte and anything above the window depth as the full depth.
	assign len_eff = (delim_len_q == '0) ? LEN_W'(1) :
		(delim_len_q > LEN_W'(MAX_DELIM_LEN)) ? LEN_W'(MAX_DELIM_LEN) : delim_len_q;
	assign delim_row = row_t'(delim_bytes_q);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = fifo_full;

	// The window cells. Cell j compares its byte against delimiter byte j-k for every
	// candidate start offset k up to j; offsets beyond j do not involve this cell.
	for (genvar j = 0; j < MAX_DELIM_LEN; j++) begin : g_cell
		for (genvar k = 0; k < MAX_DELIM_LEN; k++) begin : g_view
			if (k <= j) begin : g_on
				assign dview_a[j][k] = delim_row[j-k];
			end else begin : g_off
				assign dview_a[j][k] = '0;
			end
		end

		assign take_new[j] = byte_valid && (fill_q == FILL_W'(j));

		sds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.new_byte  (data_byte),
			.take_new  (take_new[j]),
			.load      (win_load),
			.next_byte (next_row[j]),
			.dview     (dview_a[j]),
			.p_byte    (p_row[j]),
			.eq        (eq_m[j])
		);
	end

	// Window resolution. With the new byte written in, the window holds f bytes. The
	// smallest offset k whose tail still reads as a delimiter prefix of at most len_eff bytes
	// decides everything: the k bytes in front are content, and a tail of exactly len_eff
	// bytes is a complete delimiter.
	always_comb begin
		logic all_eq;

		f = LEN_W'(fill_q) + LEN_W'(byte_valid);
		cand = '0;
		for (int k = 0; k < MAX_DELIM_LEN; k++) begin
			all_eq = 1'b1;
			for (int j = 0; j < MAX_DELIM_LEN; j++) begin
				if (j >= k && LEN_W'(j) < f) begin
					all_eq = all_eq & eq_m[j][k];
				end
			end
			cand[k] = (LEN_W'(k) >= f) || (((f - LEN_W'(k)) <= len_eff) && all_eq);
		end

		k_sel = LEN_W'(MAX_DELIM_LEN);
		for (int k = MAX_DELIM_LEN - 1; k >= 0; k--) begin
			if (cand[k]) begin
				k_sel = LEN_W'(k);
			end
		end

		rem = f - k_sel;
		hit = byte_valid && (rem == len_eff);

		// Content bytes always form a prefix of the window: the released ones, plus at the
		// end of a stream without a match the bytes that are flushed.
		if (hit) begin
			nc = k_sel;
		end else if (stream_last) begin
			nc = f;
		end else if (byte_valid) begin
			nc = k_sel;
		end else begin
			nc = '0;
		end

		// Surviving bytes move down by k_sel cells.
		for (int j = 0; j < MAX_DELIM_LEN; j++) begin
			next_row[j] = '0;
			for (int s = 0; s < MAX_DELIM_LEN; s++) begin
				if (k_sel == LEN_W'(s) && (j + s) < MAX_DELIM_LEN) begin
					next_row[j] = p_row[(j + s) % MAX_DELIM_LEN];
				end
			end
		end
	end

	assign win_load = in_acc && byte_valid && !hit && !stream_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			if (hit || stream_last) begin
				fill_q <= '0;
			end else if (byte_valid) begin
				fill_q <= rem[FILL_W-1:0];
			end
		end
	end

	// A request that produces no result (a byte held in the window, or a bare item without
	// an end mark) does not enter the queue.
	assign push_desc.bytes     = p_row;
	assign push_desc.n_content = nc;
	assign push_desc.match     = hit;
	assign push_desc.n_keep    = (hit && keep_q) ? len_eff : '0;
	assign push_desc.last      = stream_last;
	assign push = in_acc && ((nc != '0) || hit || stream_last);

	sds_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_desc),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.avail     (fifo_avail),
		.head_data (head_desc)
	);

	sds_expander u_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_avail (fifo_avail),
		.desc       (head_desc),
		.desc_pop   (fifo_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign out_byte     = res.out_byte;
	assign out_has_byte = res.out_has_byte;
	assign segment_kind = res.segment_kind;
	assign segment_end  = res.segment_end;
	assign stream_end   = res.stream_end;
	assign burst_last   = res.burst_last;

	// The closing mark of a stream is a pure mark and always ends its burst.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> burst_last && segment_end && !out_has_byte)
		else $error("stream end result is not a closing mark at the end of its burst");

	// A mark never carries a byte value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has_byte |-> out_byte == '0)
		else $error("mark result carries a nonzero byte");

	// Ending a stream or completing a delimiter empties the window.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (stream_last || hit) |=> fill_q == '0)
		else $error("window not emptied after match or stream end");

	// Every request that ends a stream leaves work for the expander.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && stream_last |=> fifo_avail || out_valid)
		else $error("stream end request produced no results");

endmodule
